// ----- hw/rtl/heap_sort_engine_top_defines.svh -----
// ----------------------------------------------------------------------------
// Heap sort engine assertion macros
// Shorthand for clocked assertions used at the top level.
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_TOP_DEFINES_SVH
`define HEAP_SORT_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define HSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine package
// Sizes, microcode step names, control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STEP_W   = 5;

  typedef logic [STEP_W-1:0] step_t;

  // microcode step addresses
  localparam step_t ST_LOAD       = STEP_W'(0);
  localparam step_t ST_BUILD_INIT = STEP_W'(1);
  localparam step_t ST_BUILD_TEST = STEP_W'(2);
  localparam step_t ST_BUILD_NODE = STEP_W'(3);
  localparam step_t ST_SIFT_RD    = STEP_W'(4);
  localparam step_t ST_SIFT_LD    = STEP_W'(5);
  localparam step_t ST_SIFT_CHILD = STEP_W'(6);
  localparam step_t ST_SIFT_LEFT  = STEP_W'(7);
  localparam step_t ST_SIFT_PICK  = STEP_W'(8);
  localparam step_t ST_SIFT_MOVE  = STEP_W'(9);
  localparam step_t ST_SIFT_PUT   = STEP_W'(10);
  localparam step_t ST_SIFT_RET   = STEP_W'(11);
  localparam step_t ST_P2_TEST    = STEP_W'(12);
  localparam step_t ST_P2_RD_ROOT = STEP_W'(13);
  localparam step_t ST_P2_RD_END  = STEP_W'(14);
  localparam step_t ST_P2_SWAP    = STEP_W'(15);
  localparam step_t ST_P2_INIT    = STEP_W'(16);
  localparam step_t ST_EMIT_INIT  = STEP_W'(17);
  localparam step_t ST_EMIT_RD    = STEP_W'(18);
  localparam step_t ST_EMIT_PUT   = STEP_W'(19);
  localparam step_t ST_EMIT_NEXT  = STEP_W'(20);
  localparam step_t ST_EMIT_DONE  = STEP_W'(21);
  localparam step_t ST_LAST       = ST_EMIT_DONE;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_BUILD_INIT,
    OP_BUILD_NODE,
    OP_RD_NODE,
    OP_LD_NV,
    OP_CHILD,
    OP_LD_LEFT,
    OP_PICK,
    OP_MOVE,
    OP_PUT_NV,
    OP_P2_INIT,
    OP_RD_ROOT,
    OP_RD_END,
    OP_SWAP,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_EMIT_PUT,
    OP_CLEAR
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NOT_ACC_LAST,
    COND_N_LT2,
    COND_K_ZERO,
    COND_C_GT_LAST,
    COND_C_EQ_LAST,
    COND_CV_GT,
    COND_NOT_PH2,
    COND_END_ZERO,
    COND_OUT_BUSY,
    COND_IDX_LT_N
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic acc_last;
    logic n_lt2;
    logic k_zero;
    logic c_gt_last;
    logic c_eq_last;
    logic cv_gt;
    logic not_ph2;
    logic end_zero;
    logic out_busy;
    logic idx_lt_n;
  } status_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t cw;
    cw = '{op: OP_NOP, cond: COND_ALWAYS, target: ST_LOAD};
    unique case (s)
      ST_LOAD:       cw = '{op: OP_LOAD,       cond: COND_NOT_ACC_LAST, target: ST_LOAD};
      ST_BUILD_INIT: cw = '{op: OP_BUILD_INIT, cond: COND_N_LT2,        target: ST_EMIT_INIT};
      ST_BUILD_TEST: cw = '{op: OP_NOP,        cond: COND_K_ZERO,       target: ST_P2_INIT};
      ST_BUILD_NODE: cw = '{op: OP_BUILD_NODE, cond: COND_NEVER,        target: ST_LOAD};
      ST_SIFT_RD:    cw = '{op: OP_RD_NODE,    cond: COND_NEVER,        target: ST_LOAD};
      ST_SIFT_LD:    cw = '{op: OP_LD_NV,      cond: COND_NEVER,        target: ST_LOAD};
      ST_SIFT_CHILD: cw = '{op: OP_CHILD,      cond: COND_C_GT_LAST,    target: ST_SIFT_PUT};
      ST_SIFT_LEFT:  cw = '{op: OP_LD_LEFT,    cond: COND_C_EQ_LAST,    target: ST_SIFT_MOVE};
      ST_SIFT_PICK:  cw = '{op: OP_PICK,       cond: COND_NEVER,        target: ST_LOAD};
      ST_SIFT_MOVE:  cw = '{op: OP_MOVE,       cond: COND_CV_GT,        target: ST_SIFT_CHILD};
      ST_SIFT_PUT:   cw = '{op: OP_PUT_NV,     cond: COND_NEVER,        target: ST_LOAD};
      ST_SIFT_RET:   cw = '{op: OP_NOP,        cond: COND_NOT_PH2,      target: ST_BUILD_TEST};
      ST_P2_TEST:    cw = '{op: OP_NOP,        cond: COND_END_ZERO,     target: ST_EMIT_INIT};
      ST_P2_RD_ROOT: cw = '{op: OP_RD_ROOT,    cond: COND_NEVER,        target: ST_LOAD};
      ST_P2_RD_END:  cw = '{op: OP_RD_END,     cond: COND_NEVER,        target: ST_LOAD};
      ST_P2_SWAP:    cw = '{op: OP_SWAP,       cond: COND_ALWAYS,       target: ST_SIFT_CHILD};
      ST_P2_INIT:    cw = '{op: OP_P2_INIT,    cond: COND_ALWAYS,       target: ST_P2_TEST};
      ST_EMIT_INIT:  cw = '{op: OP_EMIT_INIT,  cond: COND_NEVER,        target: ST_LOAD};
      ST_EMIT_RD:    cw = '{op: OP_EMIT_RD,    cond: COND_NEVER,        target: ST_LOAD};
      ST_EMIT_PUT:   cw = '{op: OP_EMIT_PUT,   cond: COND_OUT_BUSY,     target: ST_EMIT_PUT};
      ST_EMIT_NEXT:  cw = '{op: OP_NOP,        cond: COND_IDX_LT_N,     target: ST_EMIT_RD};
      ST_EMIT_DONE:  cw = '{op: OP_CLEAR,      cond: COND_ALWAYS,       target: ST_LOAD};
      default:       cw = '{op: OP_NOP,        cond: COND_ALWAYS,       target: ST_LOAD};
    endcase
    return cw;
  endfunction

endpackage

// ----- hw/rtl/hse_in_if.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine input channel
// Valid/ready channel carrying one element and its last marker.
// ----------------------------------------------------------------------------
interface hse_in_if;
  import hse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- hw/rtl/hse_out_if.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine result channel
// Valid/ready channel carrying one sorted element with its flags.
// ----------------------------------------------------------------------------
interface hse_out_if;
  import hse_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     final_res;
  logic                     overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

// ----- hw/rtl/hse_sequencer.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine sequencer
// Step counter over the microcode ROM with conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module hse_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  hse_pkg::status_t status,
  output hse_pkg::ctrl_t   ctrl,
  output hse_pkg::step_t   step
);
  import hse_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  take_jump;

  assign ctrl = ucode(step_r);
  assign step = step_r;

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:        take_jump = 1'b0;
      COND_ALWAYS:       take_jump = 1'b1;
      COND_NOT_ACC_LAST: take_jump = !status.acc_last;
      COND_N_LT2:        take_jump = status.n_lt2;
      COND_K_ZERO:       take_jump = status.k_zero;
      COND_C_GT_LAST:    take_jump = status.c_gt_last;
      COND_C_EQ_LAST:    take_jump = status.c_eq_last;
      COND_CV_GT:        take_jump = status.cv_gt;
      COND_NOT_PH2:      take_jump = status.not_ph2;
      COND_END_ZERO:     take_jump = status.end_zero;
      COND_OUT_BUSY:     take_jump = status.out_busy;
      COND_IDX_LT_N:     take_jump = status.idx_lt_n;
      default:           take_jump = 1'b1;
    endcase
    step_nxt = take_jump ? ctrl.target : step_r + step_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end
endmodule

// ----- hw/rtl/hse_datapath.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine datapath
// Element store, sift registers, compare logic and the output register.
// ----------------------------------------------------------------------------
module hse_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  hse_pkg::ctrl_t   ctrl,
  output hse_pkg::status_t status,
  hse_in_if.sink           in_ch,
  hse_out_if.source        out_ch
);
  import hse_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;

  logic [CNT_W-1:0]  n_r;       // stored elements of the current set
  logic              drop_r;
  logic              phase_r;   // low while building, high while extracting
  logic [CNT_W-1:0]  k_r;       // build counter, then emit index
  logic [AW-1:0]     node_r;
  logic [AW-1:0]     child_r;
  logic [AW-1:0]     lastpos_r;
  logic [AW-1:0]     end_r;
  logic [DATA_W-1:0] nv_r;      // value being sifted
  logic [DATA_W-1:0] cv_r;      // larger child value, or the old root during a swap

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_final_r;
  logic                     out_ovf_r;

  logic              in_acc;
  logic              has_room;
  logic [AW:0]       child_c;
  logic              out_busy;

  assign in_ch.ready         = (ctrl.op == OP_LOAD);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign has_room            = (n_r < CNT_W'(CAPACITY));
  assign child_c             = {node_r, 1'b1};
  assign out_busy            = out_valid_r && !out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.final_res    = out_final_r;
  assign out_ch.overflow     = out_ovf_r;

  always_comb begin
    status.acc_last  = in_acc && in_ch.last;
    status.n_lt2     = (n_r < CNT_W'(2));
    status.k_zero    = (k_r == '0);
    status.c_gt_last = (child_c > {1'b0, lastpos_r});
    status.c_eq_last = (child_r == lastpos_r);
    status.cv_gt     = ($signed(cv_r) > $signed(nv_r));
    status.not_ph2   = !phase_r;
    status.end_zero  = (end_r == '0);
    status.out_busy  = out_busy;
    status.idx_lt_n  = (k_r < n_r);
  end

  // store port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = node_r;
    mem_wd = nv_r;
    mem_re = 1'b0;
    mem_ra = node_r;
    unique case (ctrl.op)
      OP_LOAD: begin
        mem_we = in_acc && has_room;
        mem_wa = n_r[AW-1:0];
        mem_wd = in_ch.value;
      end
      OP_RD_NODE: begin
        mem_re = 1'b1;
      end
      OP_CHILD: begin
        mem_re = 1'b1;
        mem_ra = child_c[AW-1:0];
      end
      OP_LD_LEFT: begin
        mem_re = 1'b1;
        mem_ra = child_r + AW'(1);
      end
      OP_MOVE: begin
        mem_we = status.cv_gt;
        mem_wd = cv_r;
      end
      OP_PUT_NV: begin
        mem_we = 1'b1;
      end
      OP_RD_ROOT: begin
        mem_re = 1'b1;
        mem_ra = '0;
      end
      OP_RD_END: begin
        mem_re = 1'b1;
        mem_ra = end_r;
      end
      OP_SWAP: begin
        mem_we = 1'b1;
        mem_wa = end_r;
        mem_wd = cv_r;
      end
      OP_EMIT_RD: begin
        mem_re = 1'b1;
        mem_ra = k_r[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      drop_r      <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (ctrl.op != OP_EMIT_PUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctrl.op)
        OP_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              n_r <= n_r + CNT_W'(1);
            end else begin
              drop_r <= 1'b1;
            end
          end
        end
        OP_BUILD_INIT: phase_r <= 1'b0;
        OP_P2_INIT:    phase_r <= 1'b1;
        OP_EMIT_PUT: begin
          if (!out_busy) begin
            out_valid_r <= 1'b1;
          end
        end
        OP_CLEAR: begin
          n_r    <= '0;
          drop_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_BUILD_INIT: begin
        k_r       <= n_r >> 1;
        lastpos_r <= AW'(n_r - CNT_W'(1));
      end
      OP_BUILD_NODE: begin
        k_r    <= k_r - CNT_W'(1);
        node_r <= AW'(k_r - CNT_W'(1));
      end
      OP_LD_NV: nv_r <= rd_data_r;
      OP_CHILD: child_r <= child_c[AW-1:0];
      OP_LD_LEFT: cv_r <= rd_data_r;
      OP_PICK: begin
        // take the right child when it is strictly larger
        if ($signed(rd_data_r) > $signed(cv_r)) begin
          cv_r    <= rd_data_r;
          child_r <= child_r + AW'(1);
        end
      end
      OP_MOVE: begin
        if (status.cv_gt) begin
          node_r <= child_r;
        end
      end
      OP_P2_INIT: end_r <= lastpos_r;
      OP_RD_END:  cv_r  <= rd_data_r;
      OP_SWAP: begin
        // old root goes to the end slot, the end value sifts from the root
        nv_r      <= rd_data_r;
        node_r    <= '0;
        lastpos_r <= end_r - AW'(1);
        end_r     <= end_r - AW'(1);
      end
      OP_EMIT_INIT: k_r <= '0;
      OP_EMIT_PUT: begin
        if (!out_busy) begin
          out_value_r <= rd_data_r;
          out_final_r <= ((k_r + CNT_W'(1)) == n_r);
          out_ovf_r   <= drop_r;
          k_r         <= k_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end
endmodule

// ----- hw/rtl/heap_sort_engine_top.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine top level
// Collects a data set, heapsorts it in place and streams it out ascending.
//
//   channel   | dir | word                              | handshake
//   ----------+-----+-----------------------------------+-----------
//   in_if     | in  | value[31:0], last                 | valid/ready
//   out_if    | out | sorted_value[31:0], final_res,    | valid/ready
//             |     | overflow                          |
//
// Loading accepts one word per cycle. After the word marked last the set of n
// elements is heapsorted in the store and then emitted in order. Reset returns
// the step counter to loading and clears the count; the store is not cleared.
// A stalled result holds the sequencer at the emit step; the last result may
// still wait while loading of the next set begins.
// ----------------------------------------------------------------------------
`include "heap_sort_engine_top_defines.svh"

module heap_sort_engine_top (
  input  logic      clk,
  input  logic      rst_n,
  hse_in_if.sink    in_if,
  hse_out_if.source out_if
);
  import hse_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  step_t   step;
  logic    in_acc;

  assign in_acc = in_if.valid && in_if.ready;

  hse_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl),
    .step   (step)
  );

  hse_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .status (status),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  `HSE_ASSERT_NOW(a_step_range, 1'b1, step <= ST_LAST, "sequencer step beyond microcode")
  `HSE_ASSERT_NOW(a_ready_in_load, in_if.ready, step == ST_LOAD, "ready outside load step")
  `HSE_ASSERT_NEXT(a_last_starts_sort, in_acc && in_if.last, step == ST_BUILD_INIT, "no sort")
  `HSE_ASSERT_NEXT(a_word_keeps_load, in_acc && !in_if.last, step == ST_LOAD, "left load")
endmodule
